### hw/rtl/lssg_pkg.sv
// Shared types, constants and the sine table function of the log sine sweep generator.
`default_nettype none

package lssg_pkg;

   // Sine table: the top SINE_TABLE_BITS of the phase select one of 2^SINE_TABLE_BITS points
   // on the full wave; only the first quadrant, end point included, is stored.
   localparam int SINE_TABLE_BITS = 12;
   localparam int SINE_ADDR_BITS  = SINE_TABLE_BITS - 1;
   localparam int SINE_HALF       = 1 << (SINE_TABLE_BITS - 1);
   localparam int SINE_QUARTER    = 1 << (SINE_TABLE_BITS - 2);
   localparam int SINE_DEPTH      = SINE_QUARTER + 1;

   localparam int PHASE_BITS  = 48;
   localparam int INC_BITS    = 48;
   localparam int GROWTH_BITS = 48;
   localparam int AMP_BITS    = 24;
   localparam int DITHER_BITS = 17;
   localparam int SAMPLE_BITS = 24;
   localparam int MAG_BITS    = 23;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 48;

   localparam logic [INC_BITS-1:0]    START_INC_RESET = 48'd117281240296;
   localparam logic [INC_BITS-1:0]    END_INC_RESET   = 48'd117281240296107;
   localparam logic [GROWTH_BITS-1:0] GROWTH_RESET    = 48'd70368744177664;
   localparam logic [AMP_BITS-1:0]    AMP_RESET       = 24'd8388608;

   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] Q30_ONE = 64'd1 << 30;
   localparam logic [63:0] MAG_MAX = 64'd8388607;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_START_INC = 4'd0,
      CSR_END_INC   = 4'd1,
      CSR_GROWTH    = 4'd2,
      CSR_AMPLITUDE = 4'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [DITHER_BITS-1:0] dither;
      logic                          restart;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          active;
   } rsp_type;

   typedef struct packed {
      logic [INC_BITS-1:0]    start_increment;
      logic [INC_BITS-1:0]    end_increment;
      logic [GROWTH_BITS-1:0] growth_factor;
      logic [AMP_BITS-1:0]    amplitude;
   } cfg_type;

   // Sweep stage output: table address and sign of the half-wave.
   typedef struct packed {
      logic                          active;
      logic                          neg;
      logic [SINE_ADDR_BITS-1:0]     addr;
      logic signed [DITHER_BITS-1:0] dither;
   } tap_type;

   // Table stage output: unsigned sine magnitude.
   typedef struct packed {
      logic                          active;
      logic                          neg;
      logic [MAG_BITS-1:0]           mag;
      logic signed [DITHER_BITS-1:0] dither;
   } mag_type;

   typedef struct packed {
      logic load_mul;
      logic load_out;
   } scale_en_type;

   // First-quadrant sine in Q1.23, from a Taylor series to x^13 in Q30 arithmetic.
   // Only evaluated at elaboration to fill the table.
   function automatic logic [MAG_BITS-1:0] quarter_sine(input logic [SINE_ADDR_BITS-1:0] j);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      x  = (64'(j) * 64'd2 * PI_Q30) >> SINE_TABLE_BITS;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      v  = (s + 64'd64) >> 7;
      if (v > MAG_MAX) begin
         v = MAG_MAX;
      end
      return v[MAG_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/lssg_csr.sv
// Configuration registers of the log sine sweep generator.
`default_nettype none

module lssg_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                write,
   input  wire logic [lssg_pkg::CSR_INDEX_BITS-1:0] index,
   input  wire logic [lssg_pkg::CSR_DATA_BITS-1:0]  data,
   output lssg_pkg::cfg_type                        cfg_ff
);

   lssg_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (index)
            lssg_pkg::CSR_START_INC: cfg_in.start_increment = data;
            lssg_pkg::CSR_END_INC:   cfg_in.end_increment   = data;
            lssg_pkg::CSR_GROWTH:    cfg_in.growth_factor   = data;
            lssg_pkg::CSR_AMPLITUDE: cfg_in.amplitude       = data[lssg_pkg::AMP_BITS-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_increment <= lssg_pkg::START_INC_RESET;
         cfg_ff.end_increment   <= lssg_pkg::END_INC_RESET;
         cfg_ff.growth_factor   <= lssg_pkg::GROWTH_RESET;
         cfg_ff.amplitude       <= lssg_pkg::AMP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/lssg_sweep.sv
// Phase and increment state of the sweep, with the increment growth multiplier.
`default_nettype none

module lssg_sweep (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lssg_pkg::cfg_type cfg,
   input  wire logic              take,
   input  wire lssg_pkg::req_type req,
   output lssg_pkg::tap_type      tap_ff
);

   localparam int PB = lssg_pkg::PHASE_BITS;
   localparam int IB = lssg_pkg::INC_BITS;
   localparam int TB = lssg_pkg::SINE_TABLE_BITS;
   localparam int AB = lssg_pkg::SINE_ADDR_BITS;

   logic [PB-1:0] phase_ff;
   logic [PB-1:0] phase_in;
   logic [IB-1:0] inc_ff;
   logic [IB-1:0] inc_in;
   logic [PB-1:0] phase_eff;
   logic [IB-1:0] inc_eff;
   logic          active;

   logic [23:0] ih;
   logic [23:0] il;
   logic [23:0] gh;
   logic [23:0] gl;
   logic [47:0] hh;
   logic [47:0] ll;
   logic [48:0] mid;
   logic [48:0] low_sum;
   logic [51:0] grown_wide;
   logic [IB-1:0] grown;

   logic [TB-1:0] k;
   logic [AB-1:0] kk;
   logic [AB-1:0] j;
   lssg_pkg::tap_type tap_in;

   // A restart takes effect before the sample of the same transfer.
   assign phase_eff = req.restart ? '0 : phase_ff;
   assign inc_eff   = req.restart ? cfg.start_increment : inc_ff;
   assign active    = (inc_eff <= cfg.end_increment);

   // Increment times growth factor in Q2.46, from four 24 by 24 partial products.
   assign ih  = inc_eff[47:24];
   assign il  = inc_eff[23:0];
   assign gh  = cfg.growth_factor[47:24];
   assign gl  = cfg.growth_factor[23:0];
   assign hh  = 48'(ih) * 48'(gh);
   assign ll  = 48'(il) * 48'(gl);
   assign mid = 49'(ih) * 49'(gl) + 49'(il) * 49'(gh);
   assign low_sum    = {1'b0, ll} + {1'b0, mid[23:0], 24'd0};
   assign grown_wide = (({4'd0, hh} + 52'(mid[48:24])) << 2) + 52'(low_sum[48:46]);
   assign grown      = (|grown_wide[51:48]) ? '1 : grown_wide[IB-1:0];

   always_comb begin
      if (active) begin
         phase_in = phase_eff + inc_eff;
         inc_in   = grown;
      end else begin
         phase_in = phase_eff;
         inc_in   = inc_eff;
      end
   end

   // Fold the full-wave index onto the first quadrant.
   assign k  = phase_eff[PB-1 -: TB];
   assign kk = k[TB-2:0];

   always_comb begin
      if (kk > AB'(lssg_pkg::SINE_QUARTER)) begin
         j = AB'(TB'(lssg_pkg::SINE_HALF) - {1'b0, kk});
      end else begin
         j = kk;
      end
      tap_in.active = active;
      tap_in.neg    = k[TB-1];
      tap_in.addr   = j;
      tap_in.dither = req.dither;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         inc_ff   <= lssg_pkg::START_INC_RESET;
      end else if (take) begin
         phase_ff <= phase_in;
         inc_ff   <= inc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         tap_ff <= tap_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/lssg_sine_rom.sv
// Quarter-wave sine table with registered read.
`default_nettype none

module lssg_sine_rom (
   input  wire logic              clock,
   input  wire logic              load,
   input  wire lssg_pkg::tap_type tap,
   output lssg_pkg::mag_type      mag_ff
);

   logic [lssg_pkg::MAG_BITS-1:0] rom [lssg_pkg::SINE_DEPTH];

   for (genvar g = 0; g < lssg_pkg::SINE_DEPTH; g++) begin : g_rom
      assign rom[g] = lssg_pkg::quarter_sine(lssg_pkg::SINE_ADDR_BITS'(g));
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mag_ff.active <= tap.active;
         mag_ff.neg    <= tap.neg;
         mag_ff.mag    <= rom[tap.addr];
         mag_ff.dither <= tap.dither;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/lssg_scale.sv
// Amplitude scaling, rounding, dither addition and saturation into the result register.
`default_nettype none

module lssg_scale (
   input  wire logic                                  clock,
   input  wire lssg_pkg::scale_en_type                en,
   input  wire logic [lssg_pkg::AMP_BITS-1:0]         amplitude,
   input  wire lssg_pkg::mag_type                     mag,
   output lssg_pkg::rsp_type                          rsp_ff
);

   localparam int SB = lssg_pkg::SAMPLE_BITS;
   localparam int DB = lssg_pkg::DITHER_BITS;

   logic signed [SB-1:0] sine_val;
   logic signed [48:0]   prod_full;
   logic signed [47:0]   prod_ff;
   logic signed [47:0]   prod_in;
   logic                 active_ff;
   logic signed [DB-1:0] dither_ff;

   logic signed [48:0]   rounded;
   logic signed [25:0]   scaled;
   logic signed [26:0]   summed;
   lssg_pkg::rsp_type    rsp_in;

   assign sine_val  = mag.neg ? -$signed({1'b0, mag.mag}) : $signed({1'b0, mag.mag});
   assign prod_full = 49'(sine_val) * $signed({25'd0, amplitude});
   // The magnitude of the product stays below 2^47.
   assign prod_in   = prod_full[47:0];

   always_ff @(posedge clock) begin
      if (en.load_mul) begin
         prod_ff   <= prod_in;
         active_ff <= mag.active;
         dither_ff <= mag.dither;
      end
   end

   // Round half up from Q2.46 to Q1.23, then add the dither and clamp.
   assign rounded = 49'(prod_ff) + 49'sd4194304;
   assign scaled  = rounded[48:23];
   assign summed  = 27'(scaled) + 27'(dither_ff);

   always_comb begin
      rsp_in.active = active_ff;
      if (!active_ff) begin
         rsp_in.sample = '0;
      end else if (summed > 27'sd8388607) begin
         rsp_in.sample = 24'sd8388607;
      end else if (summed < -27'sd8388608) begin
         rsp_in.sample = -24'sd8388608;
      end else begin
         rsp_in.sample = summed[SB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/log_sine_sweep_generator.sv
// Top level of the log sine sweep generator: handshakes, pipeline valids and configuration port.
`default_nettype none

// Exponential sine sweep: each request transfer yields one response transfer carrying a
// saturated, dithered sine sample and an active flag. The block takes one request per cycle
// unless stalled, and moves each through the sweep, table, product and result registers,
// bubbles being filled whenever the response side stalls. The rate is set by the phase and
// increment loop, which closes through the 48 by 48 bit increment multiplier built from four
// 24 by 24 bit partial products. Configuration registers are written through the csr port,
// which is always ready, and must only be written while no request is in flight.
module log_sine_sweep_generator (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire lssg_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output lssg_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lssg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [lssg_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   lssg_pkg::cfg_type      cfg;
   lssg_pkg::tap_type      tap;
   lssg_pkg::mag_type      mag;
   lssg_pkg::scale_en_type scale_en;

   logic v1_ff;
   logic v1_in;
   logic v2_ff;
   logic v2_in;
   logic v3_ff;
   logic v3_in;
   logic v4_ff;
   logic v4_in;

   logic rdy1;
   logic rdy2;
   logic rdy3;
   logic rdy4;
   logic take;
   logic adv1;
   logic adv2;
   logic adv3;

   assign csr_ready = 1'b1;

   // Each stage moves on when the stage after it is empty or moving itself.
   assign rdy4 = !v4_ff || rsp_ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign take = req_valid && rdy1;
   assign adv1 = v1_ff && rdy2;
   assign adv2 = v2_ff && rdy3;
   assign adv3 = v3_ff && rdy4;

   assign v1_in = take || (v1_ff && !rdy2);
   assign v2_in = adv1 || (v2_ff && !rdy3);
   assign v3_in = adv2 || (v3_ff && !rdy4);
   assign v4_in = adv3 || (v4_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   assign req_ready         = rdy1;
   assign rsp_valid         = v4_ff;
   assign scale_en.load_mul = adv2;
   assign scale_en.load_out = adv3;

   lssg_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .write  (csr_valid),
      .index  (csr_index),
      .data   (csr_data),
      .cfg_ff (cfg)
   );

   lssg_sweep u_sweep (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .take   (take),
      .req    (req_data),
      .tap_ff (tap)
   );

   lssg_sine_rom u_rom (
      .clock  (clock),
      .load   (adv1),
      .tap    (tap),
      .mag_ff (mag)
   );

   lssg_scale u_scale (
      .clock     (clock),
      .en        (scale_en),
      .amplitude (cfg.amplitude),
      .mag       (mag),
      .rsp_ff    (rsp_data)
   );

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the log sine sweep generator with its own sweep predictor.
module tb_top;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int PIPE_LATENCY = 4;
   localparam int HOLD_CYCLES  = 80;

   // Index 8 aliases the start increment if the decoder ignores the upper index bits.
   localparam logic [lssg_pkg::CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 4'd8;

   localparam logic [lssg_pkg::INC_BITS-1:0]    INC_ALL_ONES  = 48'hFFFF_FFFF_FFFF;
   localparam logic [lssg_pkg::INC_BITS-1:0]    QUARTER_TURN  = 48'd1 << 46;
   localparam logic [lssg_pkg::INC_BITS-1:0]    HALF_TURN     = 48'd1 << 47;
   localparam logic [lssg_pkg::GROWTH_BITS-1:0] GROWTH_UNITY  = 48'd1 << 46;
   localparam logic [lssg_pkg::GROWTH_BITS-1:0] GROWTH_MIN    = 48'd1 << 45;
   localparam logic [lssg_pkg::GROWTH_BITS-1:0] GROWTH_MAX    = 48'd1 << 47;
   localparam logic [lssg_pkg::CSR_DATA_BITS-1:0] FULL_SCALE  = 48'd1 << 23;

   localparam logic signed [lssg_pkg::DITHER_BITS-1:0] DITHER_MAX = 17'sd65535;
   localparam logic signed [lssg_pkg::DITHER_BITS-1:0] DITHER_MIN = -17'sd65536;
   localparam longint SAMPLE_MAX = 64'sd8388607;
   localparam longint SAMPLE_MIN = -64'sd8388608;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid = 1'b0;
   logic                                req_ready;
   lssg_pkg::req_type                   req_data  = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   lssg_pkg::rsp_type                   rsp_data;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [lssg_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [lssg_pkg::CSR_DATA_BITS-1:0]  csr_data  = '0;

   // Predicted register contents and sweep state.
   logic [lssg_pkg::INC_BITS-1:0]    cfg_start_inc = lssg_pkg::START_INC_RESET;
   logic [lssg_pkg::INC_BITS-1:0]    cfg_end_inc   = lssg_pkg::END_INC_RESET;
   logic [lssg_pkg::GROWTH_BITS-1:0] cfg_growth    = lssg_pkg::GROWTH_RESET;
   logic [lssg_pkg::AMP_BITS-1:0]    cfg_amplitude = lssg_pkg::AMP_RESET;
   logic [lssg_pkg::PHASE_BITS-1:0]  sweep_phase   = '0;
   logic [lssg_pkg::INC_BITS-1:0]    sweep_inc     = lssg_pkg::START_INC_RESET;

   lssg_pkg::rsp_type expected_samples[$];
   int      error_count   = 0;
   int      cycle_count   = 0;
   int      send_idle_pct = 0;
   int      rsp_idle_pct  = 0;
   logic    hold_toggle   = 1'b0;
   logic    hold_seen     = 1'b0;
   int      hold_left     = 0;

   log_sine_sweep_generator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [lssg_pkg::MAG_BITS-1:0] first_quadrant_sine(input logic [63:0] j);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      x  = (j * 64'd2 * lssg_pkg::PI_Q30) >> lssg_pkg::SINE_TABLE_BITS;
      x2 = (x * x) >> 30;
      t  = lssg_pkg::Q30_ONE;
      // Horner form of the series; the divisor of step k is (2k)(2k+1), highest term first.
      for (int k = 6; k >= 1; k--) begin
         t = lssg_pkg::Q30_ONE - ((x2 * t) >> 30) / 64'(2 * k * (2 * k + 1));
      end
      s = (x * t) >> 30;
      v = (s + 64'd64) >> 7;
      if (v > lssg_pkg::MAG_MAX) begin
         v = lssg_pkg::MAG_MAX;
      end
      return v[lssg_pkg::MAG_BITS-1:0];
   endfunction

   function automatic logic signed [lssg_pkg::SAMPLE_BITS-1:0] sine_at(
      input logic [lssg_pkg::SINE_TABLE_BITS-1:0] point
   );
      logic [63:0] idx;
      logic [63:0] j;
      logic        neg;
      logic signed [lssg_pkg::SAMPLE_BITS-1:0] mag;
      idx = 64'(point);
      neg = (idx >= 64'(lssg_pkg::SINE_HALF));
      if (neg) begin
         idx = idx - 64'(lssg_pkg::SINE_HALF);
      end
      j   = (idx > 64'(lssg_pkg::SINE_QUARTER)) ? 64'(lssg_pkg::SINE_HALF) - idx : idx;
      mag = lssg_pkg::SAMPLE_BITS'(first_quadrant_sine(j));
      return neg ? -mag : mag;
   endfunction

   function automatic logic [lssg_pkg::INC_BITS-1:0] grown_increment(
      input logic [lssg_pkg::INC_BITS-1:0] inc, input logic [lssg_pkg::GROWTH_BITS-1:0] growth
   );
      logic [95:0] product;
      product = ({48'd0, inc} * {48'd0, growth}) >> 46;
      return (product > {48'd0, INC_ALL_ONES}) ? INC_ALL_ONES : product[47:0];
   endfunction

   function automatic lssg_pkg::rsp_type next_sweep_sample(input lssg_pkg::req_type item);
      lssg_pkg::rsp_type result;
      longint  product;
      longint  level;
      result = '0;
      if (item.restart) begin
         sweep_phase = '0;
         sweep_inc   = cfg_start_inc;
      end
      if (sweep_inc <= cfg_end_inc) begin
         product = longint'(sine_at(
                      sweep_phase[lssg_pkg::PHASE_BITS-1 -: lssg_pkg::SINE_TABLE_BITS]))
                   * longint'({40'd0, cfg_amplitude});
         level = ((product + (64'sd1 <<< 22)) >>> 23) + longint'($signed(item.dither));
         if (level > SAMPLE_MAX) begin
            level = SAMPLE_MAX;
         end
         if (level < SAMPLE_MIN) begin
            level = SAMPLE_MIN;
         end
         result.sample = level[lssg_pkg::SAMPLE_BITS-1:0];
         result.active = 1'b1;
         sweep_phase   = sweep_phase + sweep_inc;
         sweep_inc     = grown_increment(sweep_inc, cfg_growth);
      end
      return result;
   endfunction

   function automatic logic [47:0] random48();
      return 48'({$urandom, $urandom});
   endfunction

   function automatic logic signed [lssg_pkg::DITHER_BITS-1:0] random_dither();
      return lssg_pkg::DITHER_BITS'($urandom);
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Response side: checks every transfer and decides rsp_ready for the next edge.
   always @(posedge clock) begin
      lssg_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("response with none expected, sample %0d active %0b",
                                      rsp_data.sample, rsp_data.active));
         end else begin
            want = expected_samples.pop_front();
            if (rsp_data.sample !== want.sample) begin
               report_mismatch($sformatf("sample %0d, expected %0d",
                                         rsp_data.sample, want.sample));
            end
            if (rsp_data.active !== want.active) begin
               report_mismatch($sformatf("active %0b, expected %0b",
                                         rsp_data.active, want.active));
            end
         end
      end
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // Returns at the edge of the transfer with valid still high; the caller either sends
   // the next item at once or lowers valid in the same step.
   task automatic send_request(input logic signed [lssg_pkg::DITHER_BITS-1:0] dither,
                               input logic restart);
      lssg_pkg::req_type item;
      item.dither  = dither;
      item.restart = restart;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      expected_samples.push_back(next_sweep_sample(item));
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_register(input logic [lssg_pkg::CSR_INDEX_BITS-1:0] index,
                                 input logic [lssg_pkg::CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      case (index)
         lssg_pkg::CSR_START_INC: cfg_start_inc = value;
         lssg_pkg::CSR_END_INC:   cfg_end_inc   = value;
         lssg_pkg::CSR_GROWTH:    cfg_growth    = value;
         lssg_pkg::CSR_AMPLITUDE: cfg_amplitude = value[lssg_pkg::AMP_BITS-1:0];
         default: begin
         end
      endcase
   endtask

   task automatic configure_sweep(input logic [lssg_pkg::CSR_DATA_BITS-1:0] first_inc,
                                  input logic [lssg_pkg::CSR_DATA_BITS-1:0] last_inc,
                                  input logic [lssg_pkg::CSR_DATA_BITS-1:0] growth,
                                  input logic [lssg_pkg::CSR_DATA_BITS-1:0] amp);
      write_register(lssg_pkg::CSR_START_INC, first_inc);
      write_register(lssg_pkg::CSR_END_INC, last_inc);
      write_register(lssg_pkg::CSR_GROWTH, growth);
      write_register(lssg_pkg::CSR_AMPLITUDE, amp);
      csr_valid <= 1'b0;
   endtask

   task automatic configure_random_sweep();
      logic [47:0] first_inc;
      logic [47:0] growth;
      logic [47:0] amp;
      logic [63:0] last_inc;
      int          width;
      width     = $urandom_range(12, 47);
      first_inc = (random48() & ((48'd1 << width) - 48'd1)) + 48'd1;
      // A few octaves of sweep, so that most settings end within the block of items.
      last_inc  = (64'(first_inc) << $urandom_range(0, 5)) + 64'($urandom_range(0, 1000));
      if (last_inc > 64'(HALF_TURN)) begin
         last_inc = 64'(HALF_TURN);
      end
      if ($urandom_range(0, 7) == 0) begin
         growth = GROWTH_MIN + (random48() % (GROWTH_MAX - GROWTH_MIN + 48'd1));
      end else begin
         growth = GROWTH_UNITY + (random48() >> $urandom_range(5, 14));
      end
      if ($urandom_range(0, 5) == 0) begin
         amp = random48();
      end else begin
         amp = 48'($urandom_range(0, 1 << 23));
      end
      configure_sweep(first_inc, last_inc[47:0], growth, amp);
   endtask

   task automatic test_reset_defaults();
      send_request(17'sd0, 1'b0);
      send_request(DITHER_MAX, 1'b0);
      send_request(DITHER_MIN, 1'b1);
      send_request(17'sd1, 1'b0);
      wait_until_idle();
   endtask

   // Quarter-turn steps land on the zero crossings and the peaks; the amplitude write also carries bits above 24.
   task automatic test_peaks_and_saturation();
      configure_sweep(QUARTER_TURN, INC_ALL_ONES, GROWTH_UNITY, INC_ALL_ONES);
      send_request(DITHER_MAX, 1'b1);
      send_request(DITHER_MAX, 1'b0);
      send_request(DITHER_MIN, 1'b0);
      send_request(DITHER_MIN, 1'b0);
      wait_until_idle();
      configure_sweep(QUARTER_TURN, INC_ALL_ONES, GROWTH_UNITY, FULL_SCALE);
      send_request(17'sd0, 1'b1);
      send_request(17'sd1, 1'b0);
      send_request(-17'sd1, 1'b0);
      wait_until_idle();
   endtask

   task automatic test_zero_increment();
      configure_sweep('0, 48'd1, GROWTH_MAX, FULL_SCALE);
      send_request(17'sd5, 1'b1);
      send_request(-17'sd5, 1'b0);
      send_request(17'sd0, 1'b0);
      wait_until_idle();
   endtask

   // The increment saturates after the first sample, which ends the sweep until a restart.
   task automatic test_sweep_end();
      configure_sweep(HALF_TURN, HALF_TURN, GROWTH_MAX, 48'(lssg_pkg::AMP_RESET));
      send_request(17'sd0, 1'b1);
      send_request(17'sd100, 1'b0);
      send_request(-17'sd100, 1'b0);
      send_request(17'sd0, 1'b1);
      send_request(17'sd0, 1'b0);
      wait_until_idle();
   endtask

   task automatic test_low_settings_and_unmapped_write();
      configure_sweep(48'd1, 48'd1, GROWTH_MIN, '0);
      send_request(DITHER_MAX, 1'b1);
      send_request(DITHER_MIN, 1'b0);
      send_request(17'sd77, 1'b0);
      wait_until_idle();
      write_register(CSR_UNMAPPED, INC_ALL_ONES);
      csr_valid <= 1'b0;
      send_request(-17'sd1, 1'b1);
      send_request(17'sd12345, 1'b0);
      wait_until_idle();
   endtask

   task automatic test_random_traffic(input int sender_idle, input int receiver_idle);
      send_idle_pct = sender_idle;
      rsp_idle_pct  = receiver_idle;
      for (int block_no = 0; block_no < 3; block_no++) begin
         configure_random_sweep();
         for (int n = 0; n < 43; n++) begin
            send_request(random_dither(), (n == 0) || ($urandom_range(0, 19) == 0));
         end
         wait_until_idle();
      end
   endtask

   // The receiver holds off long enough for the pipeline to fill and stall the request side.
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      configure_random_sweep();
      hold_toggle <= ~hold_toggle;
      for (int n = 0; n < 40; n++) begin
         send_request(random_dither(), (n == 0));
      end
      wait_until_idle();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_peaks_and_saturation();
      test_zero_increment();
      test_sweep_end();
      test_low_settings_and_unmapped_write();
      test_random_traffic(34, 54);
      test_random_traffic(54, 34);
      test_random_traffic(0, 0);
      test_output_backpressure();
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/lssg_pkg.sv
hw/rtl/lssg_csr.sv
hw/rtl/lssg_sweep.sv
hw/rtl/lssg_sine_rom.sv
hw/rtl/lssg_scale.sv
hw/rtl/log_sine_sweep_generator.sv
verif/tb_top.sv
